[design/uart_rb_pkg.sv]
package uart_rb_pkg;

    localparam int RX_FIFO_DEPTH = 2;
    localparam int RX_PTR_W = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
    localparam int RX_CNT_W = $clog2(RX_FIFO_DEPTH + 1);

    localparam int BAUD_W   = 16;
    localparam int PERIOD_W = 20;
    localparam int ACC_W    = 21;
    localparam int BITS_W   = 4;

    localparam logic [PERIOD_W-1:0] MIN_PERIOD    = 20'd1024;
    localparam logic [BAUD_W-1:0]   MIN_BAUD      = 16'd64;
    localparam logic [ACC_W-1:0]    TICK_STEP     = 21'd64;
    localparam logic [BITS_W-1:0]   FRAME_BITS    = 4'd10;
    localparam logic [1:0]          RXMODE_DOUBLE = 2'b01;

    localparam int CA_RXCIE = 7;
    localparam int CA_TXCIE = 6;
    localparam int CA_DREIE = 5;
    localparam int CB_RXEN  = 7;
    localparam int CB_TXEN  = 6;
    localparam int CB_MPCM  = 0;
    localparam int ST_TXCIF = 6;

    localparam logic [7:0] CTRL_C_RESET = 8'h03;

    localparam logic [1:0] IRQ_RXC = 2'd0;
    localparam logic [1:0] IRQ_DRE = 2'd1;
    localparam logic [1:0] IRQ_TXC = 2'd2;

    typedef enum logic [2:0] {
        KIND_READ  = 3'd0,
        KIND_WRITE = 3'd1,
        KIND_TICK  = 3'd2,
        KIND_FRAME = 3'd3,
        KIND_ACK   = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        ADDR_RXDATAL = 4'd0,
        ADDR_RXDATAH = 4'd1,
        ADDR_TXDATAL = 4'd2,
        ADDR_TXDATAH = 4'd3,
        ADDR_STATUS  = 4'd4,
        ADDR_CTRLA   = 4'd5,
        ADDR_CTRLB   = 4'd6,
        ADDR_CTRLC   = 4'd7,
        ADDR_BAUDL   = 4'd8,
        ADDR_BAUDH   = 4'd9,
        ADDR_CTRLD   = 4'd10,
        ADDR_DBGCTRL = 4'd11
    } t_addr;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] address;
        logic [7:0] write_value;
        logic [7:0] rx_byte;
        logic       rx_ninth_bit;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_pending;
        logic [1:0] irq_source;
        logic       ack_taken;
    } t_out_item;

    typedef struct packed {
        logic       pending;
        logic [1:0] source;
    } t_irq;

    function automatic t_irq find_irq(input logic rxcif, input logic dreif,
                                      input logic txcif, input logic [7:0] ctrl_a);
        t_irq r;
        r.pending = 1'b1;
        r.source  = IRQ_RXC;
        if (rxcif && ctrl_a[CA_RXCIE]) begin
            r.source = IRQ_RXC;
        end else if (dreif && ctrl_a[CA_DREIE]) begin
            r.source = IRQ_DRE;
        end else if (txcif && ctrl_a[CA_TXCIE]) begin
            r.source = IRQ_TXC;
        end else begin
            r.pending = 1'b0;
        end
        return r;
    endfunction

endpackage

[design/uart_rb_core.sv]
module uart_rb_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  uart_rb_pkg::t_in_item i_item,
    output uart_rb_pkg::t_out_item o_result
);

    localparam int PW = uart_rb_pkg::RX_PTR_W;
    localparam int CW = uart_rb_pkg::RX_CNT_W;
    localparam int BW = uart_rb_pkg::BITS_W;
    localparam int DEPTH = uart_rb_pkg::RX_FIFO_DEPTH;

    logic [7:0] r_ctrl_a, n_ctrl_a;
    logic [7:0] r_ctrl_b, n_ctrl_b;
    logic [7:0] r_ctrl_c, n_ctrl_c;
    logic [7:0] r_ctrl_d, n_ctrl_d;
    logic [7:0] r_dbg, n_dbg;
    logic [uart_rb_pkg::BAUD_W-1:0] r_baud, n_baud;
    logic r_rxcif, n_rxcif;
    logic r_txcif, n_txcif;
    logic r_dreif, n_dreif;

    logic [7:0] r_fifo_data [DEPTH];
    logic       r_fifo_d8   [DEPTH];
    logic       r_fifo_ovf  [DEPTH];
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [PW-1:0] r_wptr, n_wptr;

    logic r_shifting, n_shifting;
    logic r_buf_full, n_buf_full;
    logic [uart_rb_pkg::BITS_W-1:0]   r_bits, n_bits;
    logic [uart_rb_pkg::PERIOD_W-1:0] r_period, n_period;
    logic [uart_rb_pkg::ACC_W-1:0]    r_acc, n_acc;

    logic          fifo_we;
    logic          fifo_ovf_set;
    logic [PW-1:0] wptr_last;
    logic [PW-1:0] rptr_next;
    logic [PW-1:0] wptr_next;

    logic                             tick_start;
    logic [uart_rb_pkg::PERIOD_W-1:0] period_new;
    logic [uart_rb_pkg::PERIOD_W-1:0] period_eff;
    logic [uart_rb_pkg::ACC_W-1:0]    acc_base;
    logic [uart_rb_pkg::ACC_W-1:0]    acc_sum;
    logic [uart_rb_pkg::BITS_W-1:0]   bits_base;
    logic [uart_rb_pkg::BITS_W-1:0]   bits_dec;
    logic                             bit_done;

    uart_rb_pkg::t_irq irq_before;
    uart_rb_pkg::t_irq irq_after;
    logic [7:0]        rd;
    logic              ack;

    assign rptr_next = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
    assign wptr_next = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
    assign wptr_last = (r_wptr == '0) ? PW'(DEPTH - 1) : r_wptr - PW'(1);

    // transmit timing for a tick item
    always_comb begin
        tick_start = !r_shifting && r_buf_full;
        if (r_baud > uart_rb_pkg::MIN_BAUD) begin
            if (r_ctrl_b[2:1] == uart_rb_pkg::RXMODE_DOUBLE) begin
                period_new = {1'b0, r_baud, 3'b000};
            end else begin
                period_new = {r_baud, 4'b0000};
            end
        end else begin
            period_new = uart_rb_pkg::MIN_PERIOD;
        end
        period_eff = tick_start ? period_new : r_period;
        acc_base   = tick_start ? '0 : r_acc;
        bits_base  = tick_start ? uart_rb_pkg::FRAME_BITS : r_bits;
        acc_sum    = acc_base + uart_rb_pkg::TICK_STEP;
        bit_done   = (acc_sum >= {1'b0, period_eff});
        bits_dec   = (bits_base != '0) ? bits_base - BW'(1) : bits_base;
    end

    assign irq_before = uart_rb_pkg::find_irq(r_rxcif, r_dreif, r_txcif, r_ctrl_a);

    always_comb begin
        n_ctrl_a     = r_ctrl_a;
        n_ctrl_b     = r_ctrl_b;
        n_ctrl_c     = r_ctrl_c;
        n_ctrl_d     = r_ctrl_d;
        n_dbg        = r_dbg;
        n_baud       = r_baud;
        n_rxcif      = r_rxcif;
        n_txcif      = r_txcif;
        n_dreif      = r_dreif;
        n_count      = r_count;
        n_rptr       = r_rptr;
        n_wptr       = r_wptr;
        n_shifting   = r_shifting;
        n_buf_full   = r_buf_full;
        n_bits       = r_bits;
        n_period     = r_period;
        n_acc        = r_acc;
        fifo_we      = 1'b0;
        fifo_ovf_set = 1'b0;
        rd           = '0;
        ack          = 1'b0;
        case (i_item.kind)
            uart_rb_pkg::KIND_READ: begin
                case (i_item.address)
                    uart_rb_pkg::ADDR_RXDATAL: begin
                        if (r_count != '0) begin
                            rd      = r_fifo_data[r_rptr];
                            n_rptr  = rptr_next;
                            n_count = r_count - CW'(1);
                            if (r_count == CW'(1)) begin
                                n_rxcif = 1'b0;
                            end
                        end
                    end
                    uart_rb_pkg::ADDR_RXDATAH: begin
                        if (r_count != '0) begin
                            rd = {r_rxcif, r_fifo_ovf[r_rptr], 5'b00000, r_fifo_d8[r_rptr]};
                        end
                    end
                    uart_rb_pkg::ADDR_STATUS:  rd = {r_rxcif, r_txcif, r_dreif, 5'b00000};
                    uart_rb_pkg::ADDR_CTRLA:   rd = r_ctrl_a;
                    uart_rb_pkg::ADDR_CTRLB:   rd = r_ctrl_b;
                    uart_rb_pkg::ADDR_CTRLC:   rd = r_ctrl_c;
                    uart_rb_pkg::ADDR_BAUDL:   rd = r_baud[7:0];
                    uart_rb_pkg::ADDR_BAUDH:   rd = r_baud[15:8];
                    uart_rb_pkg::ADDR_CTRLD:   rd = r_ctrl_d;
                    uart_rb_pkg::ADDR_DBGCTRL: rd = r_dbg;
                    default:                   rd = '0;
                endcase
            end
            uart_rb_pkg::KIND_WRITE: begin
                case (i_item.address)
                    uart_rb_pkg::ADDR_TXDATAL: begin
                        if (r_ctrl_b[uart_rb_pkg::CB_TXEN]) begin
                            n_buf_full = 1'b1;
                            n_dreif    = 1'b0;
                            n_txcif    = 1'b0;
                        end
                    end
                    uart_rb_pkg::ADDR_STATUS: begin
                        if (i_item.write_value[uart_rb_pkg::ST_TXCIF]) begin
                            n_txcif = 1'b0;
                        end
                    end
                    uart_rb_pkg::ADDR_CTRLA:   n_ctrl_a = i_item.write_value;
                    uart_rb_pkg::ADDR_CTRLB:   n_ctrl_b = i_item.write_value;
                    uart_rb_pkg::ADDR_CTRLC:   n_ctrl_c = i_item.write_value;
                    uart_rb_pkg::ADDR_BAUDL:   n_baud[7:0] = i_item.write_value;
                    uart_rb_pkg::ADDR_BAUDH:   n_baud[15:8] = i_item.write_value;
                    uart_rb_pkg::ADDR_CTRLD:   n_ctrl_d = i_item.write_value;
                    uart_rb_pkg::ADDR_DBGCTRL: n_dbg = i_item.write_value;
                    default: begin
                    end
                endcase
            end
            uart_rb_pkg::KIND_TICK: begin
                if (tick_start) begin
                    n_buf_full = 1'b0;
                    n_dreif    = 1'b1;
                    n_period   = period_new;
                end
                if (r_shifting || tick_start) begin
                    n_shifting = 1'b1;
                    n_acc      = acc_sum;
                    n_bits     = bits_base;
                    if (bit_done) begin
                        n_acc  = acc_sum - {1'b0, period_eff};
                        n_bits = bits_dec;
                        if (bits_dec == '0) begin
                            n_shifting = 1'b0;
                            n_txcif    = 1'b1;
                        end
                    end
                end
            end
            uart_rb_pkg::KIND_FRAME: begin
                if (r_ctrl_b[uart_rb_pkg::CB_RXEN]
                        && !(r_ctrl_b[uart_rb_pkg::CB_MPCM] && !i_item.rx_ninth_bit)) begin
                    if (r_count < CW'(DEPTH)) begin
                        fifo_we = 1'b1;
                        n_wptr  = wptr_next;
                        n_count = r_count + CW'(1);
                        n_rxcif = 1'b1;
                    end else begin
                        fifo_ovf_set = 1'b1;
                    end
                end
            end
            uart_rb_pkg::KIND_ACK: begin
                if (irq_before.pending) begin
                    ack = 1'b1;
                    if (irq_before.source == uart_rb_pkg::IRQ_TXC) begin
                        n_txcif = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign irq_after = uart_rb_pkg::find_irq(n_rxcif, n_dreif, n_txcif, n_ctrl_a);

    always_comb begin
        o_result.read_data   = rd;
        o_result.irq_pending = irq_after.pending;
        o_result.irq_source  = irq_after.source;
        o_result.ack_taken   = ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_a   <= '0;
            r_ctrl_b   <= '0;
            r_ctrl_c   <= uart_rb_pkg::CTRL_C_RESET;
            r_ctrl_d   <= '0;
            r_dbg      <= '0;
            r_baud     <= '0;
            r_rxcif    <= 1'b0;
            r_txcif    <= 1'b0;
            r_dreif    <= 1'b1;
            r_count    <= '0;
            r_rptr     <= '0;
            r_wptr     <= '0;
            r_shifting <= 1'b0;
            r_buf_full <= 1'b0;
            r_bits     <= '0;
            r_period   <= '0;
            r_acc      <= '0;
        end else if (i_step) begin
            r_ctrl_a   <= n_ctrl_a;
            r_ctrl_b   <= n_ctrl_b;
            r_ctrl_c   <= n_ctrl_c;
            r_ctrl_d   <= n_ctrl_d;
            r_dbg      <= n_dbg;
            r_baud     <= n_baud;
            r_rxcif    <= n_rxcif;
            r_txcif    <= n_txcif;
            r_dreif    <= n_dreif;
            r_count    <= n_count;
            r_rptr     <= n_rptr;
            r_wptr     <= n_wptr;
            r_shifting <= n_shifting;
            r_buf_full <= n_buf_full;
            r_bits     <= n_bits;
            r_period   <= n_period;
            r_acc      <= n_acc;
        end
    end

    // receive fifo storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_step && fifo_we) begin
            r_fifo_data[r_wptr] <= i_item.rx_byte;
            r_fifo_d8[r_wptr]   <= i_item.rx_ninth_bit;
            r_fifo_ovf[r_wptr]  <= 1'b0;
        end else if (i_step && fifo_ovf_set) begin
            r_fifo_ovf[wptr_last] <= 1'b1;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("rx count beyond fifo depth");

    a_shift_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shifting |-> (r_bits != '0))
        else $error("shifting with no bits left");

    a_acc_below_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shifting |-> (r_acc < {1'b0, r_period}))
        else $error("accumulator not below bit period");

    a_rx_flag_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rxcif == (r_count != '0))
        else $error("receive flag out of step with fifo count");

endmodule

[design/uart_register_block_with_tx_timing.sv]
// an accepted transaction waits in the input register, and its result is held in the output register
// throughput: one transaction per cycle unless the output stalls, transmit timing and fifo update done in one pass
// the output register decouples the sides, so input is taken while a result waits if the input register is empty
// reset: synchronous active low, registers return to their documented defaults
// fifo contents are not cleared by reset and are only read once written
module uart_register_block_with_tx_timing (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  uart_rb_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output uart_rb_pkg::t_out_item o_out_item
);

    logic                   r_in_valid;
    uart_rb_pkg::t_in_item  r_in_item;
    logic                   r_out_valid;
    uart_rb_pkg::t_out_item r_out_item;
    uart_rb_pkg::t_out_item result;
    logic                   advance;
    logic                   step;

    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    uart_rb_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_src_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.irq_source != 2'd3))
        else $error("illegal interrupt source");

    a_src_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.irq_pending) |-> (o_out_item.irq_source == '0))
        else $error("source set without pending interrupt");

    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_out_valid)
        else $error("processed transaction gave no result");

endmodule
